FILE: rtl/core/sap_pkg.sv
// sap_pkg: shared types and constants of the shelf atlas packer
// no dependencies; used by every file in rtl/core
package sap_pkg;

    // shelf storage depth
    localparam int MAX_SHELVES = 64;
    localparam int SLOT_W      = $clog2(MAX_SHELVES);
    localparam int CNT_W       = $clog2(MAX_SHELVES + 1);

    // field widths
    localparam int DIM_W    = 15;
    localparam int MARGIN_W = 4;
    localparam int OFS_W    = 14;
    localparam int ID_W     = 16;
    localparam int PAD_W    = DIM_W + 1;
    localparam int SUM_W    = DIM_W + 2;

    // configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = DIM_W;
    localparam logic [CFG_IDX_W-1:0] REG_ATLAS_SIDE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MARGIN     = 1'd1;

    localparam logic [DIM_W-1:0]    SIDE_RESET   = 15'd4096;
    localparam logic [MARGIN_W-1:0] MARGIN_RESET = 4'd1;

    // one stored shelf
    typedef struct packed {
        logic [DIM_W-1:0] top;
        logic [DIM_W-1:0] height;
        logic [DIM_W-1:0] fill;
    } t_shelf;

    // write request into the shelf store
    typedef struct packed {
        logic              en;
        logic [SLOT_W-1:0] addr;
        t_shelf            data;
    } t_store_wr;

    // operands of the shared add/compare unit
    typedef struct packed {
        logic [SUM_W-1:0] a;
        logic [SUM_W-1:0] b;
        logic [SUM_W-1:0] limit;
    } t_alu_req;

    typedef struct packed {
        logic [SUM_W-1:0] sum;
        logic             le;
    } t_alu_rsp;

endpackage

FILE: rtl/core/sap_req_if.sv
// sap_req_if: request channel (rectangle size) with valid/ready
// depends on sap_pkg
interface sap_req_if;
    logic                      valid;
    logic                      ready;
    logic [sap_pkg::DIM_W-1:0] rect_width;
    logic [sap_pkg::DIM_W-1:0] rect_height;

    modport source (output valid, output rect_width, output rect_height, input ready);
    modport sink   (input valid, input rect_width, input rect_height, output ready);
endinterface

FILE: rtl/core/sap_res_if.sv
// sap_res_if: result channel (placement) with valid/ready
// depends on sap_pkg
interface sap_res_if;
    logic                      valid;
    logic                      ready;
    logic                      accepted;
    logic [sap_pkg::OFS_W-1:0] offset_x;
    logic [sap_pkg::OFS_W-1:0] offset_y;
    logic [sap_pkg::ID_W-1:0]  rect_id;
    logic [sap_pkg::DIM_W-1:0] used_width;
    logic [sap_pkg::DIM_W-1:0] used_height;

    modport source (output valid, output accepted, output offset_x, output offset_y,
                    output rect_id, output used_width, output used_height, input ready);
    modport sink   (input valid, input accepted, input offset_x, input offset_y,
                    input rect_id, input used_width, input used_height, output ready);
endinterface

FILE: rtl/core/shelf_atlas_packer.sv
// shelf_atlas_packer: first-fit shelf packing of rectangles into a square atlas
// depends on sap_pkg, sap_req_if, sap_res_if, sap_alu, sap_store
//
// Each request (rect_width, rect_height) is padded by the margin on every side
// and placed on the first open shelf that is tall enough and has width left;
// otherwise a new shelf is opened under the last one if it stays inside the
// atlas side and a shelf slot is free. One result transaction follows every
// request transaction. The block takes one request at a time: it is ready only
// while its sequencer is idle. The shelf table is one memory read one shelf per
// cycle and the padding, fill, bottom and offset sums go through a single shared
// adder, so the time from acceptance to a valid result grows with the number of
// shelves tested (at most the open shelf count, 64). A request is padded in width
// and height, scanned against the shelves, given a new shelf if none fits, then
// placed and given its x and y offsets before the final state; an over-wide or
// unplaceable request skips to the final state. The sequencer returns to idle on
// the same edge that loads the result. A finished result waits in an output
// register, so the next request is taken while the previous result is still
// unclaimed; a result only holds up the sequencer when the output register is
// still full at the end of the next request. The shelf table needs no clearing
// after reset: only entries below the shelf count are ever read. Configuration
// (atlas_side, margin) is to be written through i_cfg_* only while idle; the
// block itself does not enforce this.
module shelf_atlas_packer (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [sap_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [sap_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    sap_req_if.sink                          i_req,
    sap_res_if.source                        o_res
);
    // sequencer states
    localparam logic [3:0] ST_IDLE  = 4'd0;  // waiting for a request
    localparam logic [3:0] ST_PADW  = 4'd1;  // padded width, over-wide test
    localparam logic [3:0] ST_PADH  = 4'd2;  // padded height
    localparam logic [3:0] ST_SCAN  = 4'd3;  // test one shelf per cycle
    localparam logic [3:0] ST_NEWS  = 4'd4;  // try to open a new shelf
    localparam logic [3:0] ST_PLACE = 4'd5;  // grow shelf fill
    localparam logic [3:0] ST_OFSX  = 4'd6;  // x offset
    localparam logic [3:0] ST_OFSY  = 4'd7;  // y offset
    localparam logic [3:0] ST_FIN   = 4'd8;  // hand result to output register

    localparam int DIM_W = sap_pkg::DIM_W;
    localparam int SUM_W = sap_pkg::SUM_W;

    // configuration
    logic [DIM_W-1:0]             r_side;
    logic [sap_pkg::MARGIN_W-1:0] r_margin;

    // packer state
    logic [sap_pkg::CNT_W-1:0] r_count, n_count;
    logic [sap_pkg::ID_W-1:0]  r_next_id, n_next_id;
    logic [DIM_W-1:0]          r_widest, n_widest;
    logic [DIM_W-1:0]          r_bottom, n_bottom;

    // per request working registers
    logic [3:0]                 r_state, n_state;
    logic [DIM_W-1:0]           r_w, n_w, r_h, n_h;
    logic [sap_pkg::PAD_W-1:0]  r_pw, n_pw, r_ph, n_ph;
    logic                       r_wide_ok, n_wide_ok;
    logic [sap_pkg::SLOT_W-1:0] r_idx, n_idx, r_slot, n_slot;
    sap_pkg::t_shelf            r_shelf, n_shelf;
    logic                       r_acc, n_acc;
    logic [sap_pkg::OFS_W-1:0]  r_ox, n_ox, r_oy, n_oy;
    logic [sap_pkg::ID_W-1:0]   r_id, n_id;

    // output register
    logic                       r_out_valid, n_out_valid;
    logic                       r_o_acc, n_o_acc;
    logic [sap_pkg::OFS_W-1:0]  r_o_ox, n_o_ox, r_o_oy, n_o_oy;
    logic [sap_pkg::ID_W-1:0]   r_o_id, n_o_id;
    logic [DIM_W-1:0]           r_o_uw, n_o_uw, r_o_uh, n_o_uh;

    sap_pkg::t_alu_req   alu_req;
    sap_pkg::t_alu_rsp   alu_rsp;
    sap_pkg::t_store_wr  st_wr;
    sap_pkg::t_shelf     st_rd;

    logic [SUM_W-1:0]          margin2;
    logic [SUM_W-1:0]          side_ext;
    logic                      height_ok;
    logic                      last_shelf;
    logic                      out_free;
    logic [sap_pkg::CNT_W-1:0] idx_next;

    sap_alu u_alu (
        .i_req (alu_req),
        .o_rsp (alu_rsp)
    );

    sap_store u_store (
        .i_clk     (i_clk),
        .i_wr      (st_wr),
        .i_rd_addr (n_idx),
        .o_rd_data (st_rd)
    );

    assign margin2  = {{(SUM_W-sap_pkg::MARGIN_W-1){1'b0}}, r_margin, 1'b0};
    assign side_ext = {2'b00, r_side};
    assign height_ok = ({1'b0, st_rd.height} >= r_ph);
    assign idx_next  = {1'b0, r_idx} + sap_pkg::CNT_W'(1);
    assign last_shelf = (idx_next == r_count);
    assign out_free   = !r_out_valid || o_res.ready;

    assign i_req.ready = (r_state == ST_IDLE);

    // sequencer
    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_next_id = r_next_id;
        n_widest  = r_widest;
        n_bottom  = r_bottom;
        n_w       = r_w;
        n_h       = r_h;
        n_pw      = r_pw;
        n_ph      = r_ph;
        n_wide_ok = r_wide_ok;
        n_idx     = r_idx;
        n_slot    = r_slot;
        n_shelf   = r_shelf;
        n_acc     = r_acc;
        n_ox      = r_ox;
        n_oy      = r_oy;
        n_id      = r_id;
        alu_req   = '0;
        alu_req.limit = side_ext;
        st_wr     = '0;

        case (r_state)
            ST_IDLE: begin
                if (i_req.valid) begin
                    n_w     = i_req.rect_width;
                    n_h     = i_req.rect_height;
                    n_acc   = 1'b0;
                    n_ox    = '0;
                    n_oy    = '0;
                    n_id    = '0;
                    n_state = ST_PADW;
                end
            end
            ST_PADW: begin
                alu_req.a = {2'b00, r_w};
                alu_req.b = margin2;
                n_pw      = alu_rsp.sum[sap_pkg::PAD_W-1:0];
                n_wide_ok = alu_rsp.le;
                n_state   = ST_PADH;
            end
            ST_PADH: begin
                alu_req.a = {2'b00, r_h};
                alu_req.b = margin2;
                n_ph      = alu_rsp.sum[sap_pkg::PAD_W-1:0];
                n_idx     = '0;
                if (!r_wide_ok) begin
                    n_state = ST_FIN;
                end else if (r_count == '0) begin
                    n_state = ST_NEWS;
                end else begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                // st_rd holds shelf r_idx
                alu_req.a = {2'b00, st_rd.fill};
                alu_req.b = {1'b0, r_pw};
                if (height_ok && alu_rsp.le) begin
                    n_slot  = r_idx;
                    n_shelf = st_rd;
                    n_state = ST_PLACE;
                end else if (last_shelf) begin
                    n_state = ST_NEWS;
                end else begin
                    n_idx = idx_next[sap_pkg::SLOT_W-1:0];
                end
            end
            ST_NEWS: begin
                alu_req.a = {2'b00, r_bottom};
                alu_req.b = {1'b0, r_ph};
                if (r_count < sap_pkg::CNT_W'(sap_pkg::MAX_SHELVES) && alu_rsp.le) begin
                    n_slot         = r_count[sap_pkg::SLOT_W-1:0];
                    n_shelf.top    = r_bottom;
                    n_shelf.height = r_ph[DIM_W-1:0];
                    n_shelf.fill   = '0;
                    n_count        = r_count + sap_pkg::CNT_W'(1);
                    n_bottom       = alu_rsp.sum[DIM_W-1:0];
                    n_state        = ST_PLACE;
                end else begin
                    n_state = ST_FIN;
                end
            end
            ST_PLACE: begin
                // write back the shelf with its grown fill
                alu_req.a       = {2'b00, r_shelf.fill};
                alu_req.b       = {1'b0, r_pw};
                st_wr.en        = 1'b1;
                st_wr.addr      = r_slot;
                st_wr.data      = r_shelf;
                st_wr.data.fill = alu_rsp.sum[DIM_W-1:0];
                if (alu_rsp.sum[DIM_W-1:0] > r_widest) begin
                    n_widest = alu_rsp.sum[DIM_W-1:0];
                end
                n_acc     = 1'b1;
                n_id      = r_next_id;
                n_next_id = r_next_id + sap_pkg::ID_W'(1);
                n_state   = ST_OFSX;
            end
            ST_OFSX: begin
                alu_req.a = {2'b00, r_shelf.fill};
                alu_req.b = {{(SUM_W-sap_pkg::MARGIN_W){1'b0}}, r_margin};
                n_ox      = alu_rsp.sum[sap_pkg::OFS_W-1:0];
                n_state   = ST_OFSY;
            end
            ST_OFSY: begin
                alu_req.a = {2'b00, r_shelf.top};
                alu_req.b = {{(SUM_W-sap_pkg::MARGIN_W){1'b0}}, r_margin};
                n_oy      = alu_rsp.sum[sap_pkg::OFS_W-1:0];
                n_state   = ST_FIN;
            end
            ST_FIN: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // output register: loaded when the sequencer finishes and the slot is free
    always_comb begin
        n_out_valid = r_out_valid;
        n_o_acc     = r_o_acc;
        n_o_ox      = r_o_ox;
        n_o_oy      = r_o_oy;
        n_o_id      = r_o_id;
        n_o_uw      = r_o_uw;
        n_o_uh      = r_o_uh;
        if (r_out_valid && o_res.ready) begin
            n_out_valid = 1'b0;
        end
        if (r_state == ST_FIN && out_free) begin
            n_out_valid = 1'b1;
            n_o_acc     = r_acc;
            n_o_ox      = r_ox;
            n_o_oy      = r_oy;
            n_o_id      = r_id;
            n_o_uw      = r_widest;
            n_o_uh      = r_bottom;
        end
    end

    // control state and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_next_id   <= '0;
            r_widest    <= '0;
            r_bottom    <= '0;
            r_out_valid <= 1'b0;
            r_side      <= sap_pkg::SIDE_RESET;
            r_margin    <= sap_pkg::MARGIN_RESET;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_next_id   <= n_next_id;
            r_widest    <= n_widest;
            r_bottom    <= n_bottom;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    sap_pkg::REG_ATLAS_SIDE: r_side   <= i_cfg_data;
                    sap_pkg::REG_MARGIN:     r_margin <= i_cfg_data[sap_pkg::MARGIN_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_w       <= n_w;
        r_h       <= n_h;
        r_pw      <= n_pw;
        r_ph      <= n_ph;
        r_wide_ok <= n_wide_ok;
        r_idx     <= n_idx;
        r_slot    <= n_slot;
        r_shelf   <= n_shelf;
        r_acc     <= n_acc;
        r_ox      <= n_ox;
        r_oy      <= n_oy;
        r_id      <= n_id;
        r_o_acc   <= n_o_acc;
        r_o_ox    <= n_o_ox;
        r_o_oy    <= n_o_oy;
        r_o_id    <= n_o_id;
        r_o_uw    <= n_o_uw;
        r_o_uh    <= n_o_uh;
    end

    assign o_res.valid       = r_out_valid;
    assign o_res.accepted    = r_o_acc;
    assign o_res.offset_x    = r_o_ox;
    assign o_res.offset_y    = r_o_oy;
    assign o_res.rect_id     = r_o_id;
    assign o_res.used_width  = r_o_uw;
    assign o_res.used_height = r_o_uh;

    // shelf count never passes the table depth
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= sap_pkg::CNT_W'(sap_pkg::MAX_SHELVES))
        else $error("shelf count beyond table depth");

    // the scan only visits open shelves
    a_scan_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |-> ({1'b0, r_idx} < r_count))
        else $error("scan index past open shelves");

    // the table is written only when a rectangle is placed
    a_write_place: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        st_wr.en |-> (r_state == ST_PLACE))
        else $error("shelf write outside placement");

    // each placement uses up exactly one identifier
    a_id_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_PLACE) |=> (r_next_id == $past(r_next_id) + sap_pkg::ID_W'(1)))
        else $error("identifier not advanced on placement");

    // a result is loaded only from the final state
    a_load_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == ST_FIN))
        else $error("result loaded outside final state");
endmodule

FILE: rtl/core/sap_alu.sv
// sap_alu: shared adder with a limit compare, used for the padding, fill, bottom and offset sums
// depends on sap_pkg
module sap_alu (
    input  sap_pkg::t_alu_req i_req,
    output sap_pkg::t_alu_rsp o_rsp
);
    always_comb begin
        o_rsp.sum = i_req.a + i_req.b;
        o_rsp.le  = (o_rsp.sum <= i_req.limit);
    end
endmodule

FILE: rtl/core/sap_store.sv
// sap_store: shelf table memory, one write and one registered read per cycle
// depends on sap_pkg
module sap_store (
    input  logic                        i_clk,
    input  sap_pkg::t_store_wr          i_wr,
    input  logic [sap_pkg::SLOT_W-1:0]  i_rd_addr,
    output sap_pkg::t_shelf             o_rd_data
);
    sap_pkg::t_shelf r_mem [sap_pkg::MAX_SHELVES];
    sap_pkg::t_shelf r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;
endmodule
